// ===== hdl/bnms_pkg.sv =====
// shared types, codes and constants of the box non-maximum suppression block
package bnms_pkg;

   localparam int MAX_BOXES_DEF = 64;
   localparam int COORD_W       = 12;
   localparam int SCORE_W       = 16;
   localparam int LIMIT_W       = 17;
   localparam int AREA_W        = 2 * COORD_W;
   localparam int PROD_W        = LIMIT_W + AREA_W;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 17'd32768;

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] w;
      logic [COORD_W-1:0] h;
      logic [SCORE_W-1:0] s;
   } box_type;

   // operations of the shared overlap unit
   typedef enum logic [2:0] {
      OP_IDLE,
      OP_AREA,
      OP_LIM,
      OP_DIFF,
      OP_MUL
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEL_RD,
      ST_SEL_CMP,
      ST_AREA,
      ST_LIM,
      ST_CHK_RD,
      ST_CHK_DIFF,
      ST_CHK_MUL,
      ST_CHK_CMP,
      ST_DECIDE,
      ST_FLUSH
   } state_type;

endpackage

// ===== hdl/box_non_maximum_suppression.sv =====
// top level of the box non-maximum suppression block with its pass sequencer
// usage:
//  - load candidates one beat at a time: a beat is taken when start is high
//    and busy is low; req_final_box marks the last candidate of a set
//  - up to MAX_BOXES candidates are stored; extra ones are dropped and the
//    set reports overflowed on every result
//  - a non-final beat leaves busy low
//  - the final beat starts the pass; busy stays high until the last result
//  - the pass repeats n rounds (n stored boxes); a round scans the store for
//    the best untaken score, forms area and limit product, steps through every
//    entry to test the candidate against each higher-ranked one (leaving early
//    on suppression) and records the decision; a flush state ends the pass
//  - the pass runs serially, limited by the single memory read port and the
//    shared overlap unit
//  - kept boxes come out in rank order, one beat per rsp_valid strobe,
//    run_end on the last; the receiver cannot stall, each beat lasts a cycle
//  - the last beat appears in the cycle busy falls
//  - csr_wr_en writes the overlap limit; write it only while idle
//  - reset empties the set and loads the default limit of one half
module box_non_maximum_suppression #(
   parameter int MAX_BOXES = bnms_pkg::MAX_BOXES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [bnms_pkg::COORD_W-1:0]        req_box_x,
   input  logic [bnms_pkg::COORD_W-1:0]        req_box_y,
   input  logic [bnms_pkg::COORD_W-1:0]        req_box_width,
   input  logic [bnms_pkg::COORD_W-1:0]        req_box_height,
   input  logic [bnms_pkg::SCORE_W-1:0]        req_box_score,
   input  logic                                req_final_box,
   output logic                                rsp_valid,
   output logic [bnms_pkg::COORD_W-1:0]        rsp_kept_x,
   output logic [bnms_pkg::COORD_W-1:0]        rsp_kept_y,
   output logic [bnms_pkg::COORD_W-1:0]        rsp_kept_width,
   output logic [bnms_pkg::COORD_W-1:0]        rsp_kept_height,
   output logic [bnms_pkg::SCORE_W-1:0]        rsp_kept_score,
   output logic                                rsp_run_end,
   output logic                                rsp_overflowed,
   input  logic                                csr_wr_en,
   input  logic [bnms_pkg::LIMIT_W-1:0]        csr_wr_data
);
   import bnms_pkg::*;

   localparam int IDX_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
   localparam int CNT_W = $clog2(MAX_BOXES + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BOXES);

   state_type state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;   // stored boxes
   logic [CNT_W-1:0] n_ff, n_in;           // boxes in this pass
   logic [CNT_W-1:0] idx_ff, idx_in;       // scan position
   logic [CNT_W-1:0] rounds_ff, rounds_in; // ranks decided so far
   logic             drop_ff, drop_in;
   logic             best_valid_ff, best_valid_in;
   logic [IDX_W-1:0] best_idx_ff, best_idx_in;
   logic             keep_ff, keep_in;
   logic             pend_valid_ff, pend_valid_in;
   logic [MAX_BOXES-1:0] taken_ff, taken_in;
   box_type          cand_ff, cand_in;
   box_type          pend_ff, pend_in;
   box_type          rsp_box_ff, rsp_box_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_end_ff, rsp_end_in;
   logic             rsp_ovf_ff, rsp_ovf_in;
   logic [LIMIT_W-1:0] limit_ff, limit_in;

   logic             wr_en;
   box_type          wr_box;
   box_type          rd_box;
   op_type           op;
   logic             hit;
   logic             idx_last;
   logic             idx_taken;

   assign wr_box = '{x: req_box_x, y: req_box_y, w: req_box_width,
                     h: req_box_height, s: req_box_score};

   bnms_store #(.DEPTH(MAX_BOXES)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (wr_box),
      .rd_addr (idx_ff[IDX_W-1:0]),
      .rd_data (rd_box)
   );

   bnms_overlap u_overlap (
      .clock (clock),
      .op    (op),
      .cand  (cand_ff),
      .other (rd_box),
      .limit (limit_ff),
      .hit   (hit)
   );

   assign idx_last  = (idx_ff + CNT_W'(1)) == n_ff;
   assign idx_taken = taken_ff[idx_ff[IDX_W-1:0]];

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      n_in          = n_ff;
      idx_in        = idx_ff;
      rounds_in     = rounds_ff;
      drop_in       = drop_ff;
      best_valid_in = best_valid_ff;
      best_idx_in   = best_idx_ff;
      keep_in       = keep_ff;
      pend_valid_in = pend_valid_ff;
      taken_in      = taken_ff;
      cand_in       = cand_ff;
      pend_in       = pend_ff;
      rsp_box_in    = rsp_box_ff;
      rsp_valid_in  = 1'b0;
      rsp_end_in    = rsp_end_ff;
      rsp_ovf_in    = rsp_ovf_ff;
      limit_in      = csr_wr_en ? csr_wr_data : limit_ff;
      wr_en         = 1'b0;
      op            = OP_IDLE;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (count_ff < CNT_MAX) begin
                  wr_en    = 1'b1;
                  count_in = count_ff + CNT_W'(1);
               end else begin
                  drop_in = 1'b1;
               end
               if (req_final_box) begin
                  n_in          = (count_ff < CNT_MAX) ? count_ff + CNT_W'(1) : count_ff;
                  idx_in        = '0;
                  rounds_in     = '0;
                  best_valid_in = 1'b0;
                  state_in      = ST_SEL_RD;
               end
            end
         end
         ST_SEL_RD: state_in = ST_SEL_CMP;
         ST_SEL_CMP: begin
            // strict compare keeps the earliest box on equal scores
            if (!idx_taken && (!best_valid_ff || rd_box.s > cand_ff.s)) begin
               cand_in       = rd_box;
               best_idx_in   = idx_ff[IDX_W-1:0];
               best_valid_in = 1'b1;
            end
            if (idx_last) begin
               idx_in   = '0;
               state_in = ST_AREA;
            end else begin
               idx_in   = idx_ff + CNT_W'(1);
               state_in = ST_SEL_RD;
            end
         end
         ST_AREA: begin
            op       = OP_AREA;
            state_in = ST_LIM;
         end
         ST_LIM: begin
            op       = OP_LIM;
            idx_in   = '0;
            keep_in  = 1'b1;
            state_in = ST_CHK_RD;
         end
         ST_CHK_RD: begin
            // only boxes of higher rank are already taken
            if (idx_taken) begin
               state_in = ST_CHK_DIFF;
            end else if (idx_last) begin
               state_in = ST_DECIDE;
            end else begin
               idx_in = idx_ff + CNT_W'(1);
            end
         end
         ST_CHK_DIFF: begin
            op       = OP_DIFF;
            state_in = ST_CHK_MUL;
         end
         ST_CHK_MUL: begin
            op       = OP_MUL;
            state_in = ST_CHK_CMP;
         end
         ST_CHK_CMP: begin
            if (hit) begin
               keep_in  = 1'b0;
               state_in = ST_DECIDE;
            end else if (idx_last) begin
               state_in = ST_DECIDE;
            end else begin
               idx_in   = idx_ff + CNT_W'(1);
               state_in = ST_CHK_RD;
            end
         end
         ST_DECIDE: begin
            taken_in[best_idx_ff] = 1'b1;
            rounds_in = rounds_ff + CNT_W'(1);
            if (keep_ff) begin
               // hold one kept box back so the last one can carry run_end
               if (pend_valid_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_box_in   = pend_ff;
                  rsp_end_in   = 1'b0;
                  rsp_ovf_in   = drop_ff;
               end
               pend_in       = cand_ff;
               pend_valid_in = 1'b1;
            end
            if ((rounds_ff + CNT_W'(1)) == n_ff) begin
               state_in = ST_FLUSH;
            end else begin
               idx_in        = '0;
               best_valid_in = 1'b0;
               state_in      = ST_SEL_RD;
            end
         end
         ST_FLUSH: begin
            rsp_valid_in  = 1'b1;
            rsp_box_in    = pend_ff;
            rsp_end_in    = 1'b1;
            rsp_ovf_in    = drop_ff;
            count_in      = '0;
            drop_in       = 1'b0;
            taken_in      = '0;
            rounds_in     = '0;
            pend_valid_in = 1'b0;
            state_in      = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         n_ff          <= '0;
         idx_ff        <= '0;
         rounds_ff     <= '0;
         drop_ff       <= 1'b0;
         best_valid_ff <= 1'b0;
         best_idx_ff   <= '0;
         keep_ff       <= 1'b0;
         pend_valid_ff <= 1'b0;
         taken_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         limit_ff      <= LIMIT_RESET;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         n_ff          <= n_in;
         idx_ff        <= idx_in;
         rounds_ff     <= rounds_in;
         drop_ff       <= drop_in;
         best_valid_ff <= best_valid_in;
         best_idx_ff   <= best_idx_in;
         keep_ff       <= keep_in;
         pend_valid_ff <= pend_valid_in;
         taken_ff      <= taken_in;
         rsp_valid_ff  <= rsp_valid_in;
         limit_ff      <= limit_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cand_ff    <= cand_in;
      pend_ff    <= pend_in;
      rsp_box_ff <= rsp_box_in;
      rsp_end_ff <= rsp_end_in;
      rsp_ovf_ff <= rsp_ovf_in;
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kept_x      = rsp_box_ff.x;
   assign rsp_kept_y      = rsp_box_ff.y;
   assign rsp_kept_width  = rsp_box_ff.w;
   assign rsp_kept_height = rsp_box_ff.h;
   assign rsp_kept_score  = rsp_box_ff.s;
   assign rsp_run_end     = rsp_end_ff;
   assign rsp_overflowed  = rsp_ovf_ff;

   // last beat of a set lands as the block goes idle
   a_end_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_run_end |-> !busy)
      else $error("run end beat while busy");

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_MAX)
      else $error("box count above capacity");

   a_taken_rounds: assert property (@(posedge clock) disable iff (reset)
      $countones(taken_ff) == int'(rounds_ff))
      else $error("taken marks disagree with decided ranks");

   a_decide_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DECIDE |-> rounds_ff < n_ff && best_valid_ff)
      else $error("decision without a selected box");

endmodule

// ===== hdl/bnms_store.sv =====
// candidate box memory, one write port and one registered read port
module bnms_store #(
   parameter int DEPTH = bnms_pkg::MAX_BOXES_DEF,
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [IDX_W-1:0]     wr_addr,
   input  bnms_pkg::box_type    wr_data,
   input  logic [IDX_W-1:0]     rd_addr,
   output bnms_pkg::box_type    rd_data
);
   import bnms_pkg::*;

   box_type mem [DEPTH];
   box_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/bnms_overlap.sv =====
// shared overlap unit: area, limit product, intersection extent and product, compare
module bnms_overlap (
   input  logic                                  clock,
   input  bnms_pkg::op_type                      op,
   input  bnms_pkg::box_type                     cand,
   input  bnms_pkg::box_type                     other,
   input  logic [bnms_pkg::LIMIT_W-1:0]          limit,
   output logic                                  hit
);
   import bnms_pkg::*;

   logic [COORD_W-1:0] dx_ff, dy_ff;
   logic [AREA_W-1:0]  prod_ff, area_ff;
   logic [PROD_W-1:0]  lim_ff;

   logic [COORD_W:0]   x1, y1, x2, y2, ca, oa;
   logic [COORD_W-1:0] dx_in, dy_in;
   logic [COORD_W-1:0] mul_a, mul_b;
   logic [AREA_W-1:0]  mul_p;

   always_comb begin
      x1 = (cand.x > other.x) ? {1'b0, cand.x} : {1'b0, other.x};
      y1 = (cand.y > other.y) ? {1'b0, cand.y} : {1'b0, other.y};
      ca = {1'b0, cand.x} + {1'b0, cand.w};
      oa = {1'b0, other.x} + {1'b0, other.w};
      x2 = (ca < oa) ? ca : oa;
      ca = {1'b0, cand.y} + {1'b0, cand.h};
      oa = {1'b0, other.y} + {1'b0, other.h};
      y2 = (ca < oa) ? ca : oa;
      // empty overlap counts as zero
      dx_in = (x2 > x1) ? COORD_W'(x2 - x1) : '0;
      dy_in = (y2 > y1) ? COORD_W'(y2 - y1) : '0;
      mul_a = (op == OP_AREA) ? cand.w : dx_ff;
      mul_b = (op == OP_AREA) ? cand.h : dy_ff;
      mul_p = AREA_W'(mul_a * mul_b);
   end

   always_ff @(posedge clock) begin
      case (op)
         OP_AREA: area_ff <= mul_p;
         OP_LIM:  lim_ff  <= PROD_W'(limit * area_ff);
         OP_DIFF: begin
            dx_ff <= dx_in;
            dy_ff <= dy_in;
         end
         OP_MUL:  prod_ff <= mul_p;
         default: ;
      endcase
   end

   assign hit = {1'b0, prod_ff, 16'b0} > lim_ff;

endmodule
